### rtl/tsch_pkg.sv
package tsch_pkg;

  localparam int ID_W        = 16;
  localparam int CNT_W       = 32;
  localparam int QUEUE_DEPTH = 64;

  // func codes
  localparam logic FUNC_ENQ   = 1'b0;
  localparam logic FUNC_SCHED = 1'b1;

  typedef struct packed {
    logic            func;
    logic [ID_W-1:0] task_id;
    logic            task_high;
    logic            prev_valid;
    logic [ID_W-1:0] prev_id;
    logic            prev_high;
  } in_req_t;

  typedef struct packed {
    logic             next_valid;
    logic [ID_W-1:0]  next_id;
    logic             kept_prev;
    logic             push_dropped;
    logic [CNT_W-1:0] local_count;
    logic [CNT_W-1:0] skip_high_count;
    logic [CNT_W-1:0] idle_count;
  } out_rsp_t;

  // classified request: enqueue carries its task, schedule carries the previous task
  typedef struct packed {
    logic            sched;
    logic            has_task;
    logic            task_high;
    logic [ID_W-1:0] task_id;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } qhead_t;

endpackage

### rtl/tsch_ram.sv
module tsch_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/tsch_front.sv
module tsch_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  tsch_pkg::in_req_t in_data,
  output tsch_pkg::qhead_t  qhead,
  input  logic              q_pop
);

  tsch_pkg::op_t op_cls;
  tsch_pkg::op_t op_q_r [2];
  logic [1:0]    count_r, count_nxt;
  logic          wr_ptr_r, rd_ptr_r;
  logic          push;
  logic          pop;

  always_comb begin
    op_cls.sched = (in_data.func == tsch_pkg::FUNC_SCHED);
    if (in_data.func == tsch_pkg::FUNC_SCHED) begin
      op_cls.has_task  = in_data.prev_valid;
      op_cls.task_high = in_data.prev_high;
      op_cls.task_id   = in_data.prev_id;
    end else begin
      op_cls.has_task  = 1'b1;
      op_cls.task_high = in_data.task_high;
      op_cls.task_id   = in_data.task_id;
    end
  end

  assign busy  = (count_r == 2'd2);
  assign push  = start && !busy;
  assign pop   = q_pop && (count_r != 2'd0);

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      op_q_r[wr_ptr_r] <= op_cls;
    end
  end

  assign qhead.valid = (count_r != 2'd0);
  assign qhead.op    = op_q_r[rd_ptr_r];

endmodule

### rtl/tsch_back.sv
module tsch_back #(
  parameter int QUEUE_DEPTH = tsch_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tsch_pkg::qhead_t   qhead,
  output logic               q_pop,
  output logic               out_valid,
  output tsch_pkg::out_rsp_t out_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int FW = AW + 1;
  localparam int IW = tsch_pkg::ID_W;
  localparam int CW = tsch_pkg::CNT_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  tsch_pkg::op_t      cur_op_r;
  tsch_pkg::out_rsp_t rsp;
  tsch_pkg::out_rsp_t out_data_r;
  logic               out_valid_r;

  logic [AW-1:0] hi_head_r, hi_head_nxt, lo_head_r, lo_head_nxt;
  logic [FW-1:0] hi_fill_r, hi_fill_nxt, lo_fill_r, lo_fill_nxt;
  logic [CW-1:0] local_r, local_nxt, skip_r, skip_nxt, idle_r, idle_nxt;

  logic          exec;
  logic          rd_en;
  logic [IW-1:0] hi_rdata, lo_rdata;
  logic          push_req, push_to_hi, push_ok;
  logic [AW-1:0] tgt_head;
  logic [FW-1:0] tgt_fill;
  logic [FW-1:0] pos_sum;
  logic [AW-1:0] waddr;

  assign exec  = (state_r == S_EXEC);
  assign q_pop = (state_r == S_IDLE) && qhead.valid;
  assign rd_en = q_pop;

  always_comb begin
    unique case (state_r)
      S_IDLE:  state_nxt = qhead.valid ? S_EXEC : S_IDLE;
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    hi_head_nxt = hi_head_r;
    lo_head_nxt = lo_head_r;
    hi_fill_nxt = hi_fill_r;
    lo_fill_nxt = lo_fill_r;
    local_nxt   = local_r;
    skip_nxt    = skip_r;
    idle_nxt    = idle_r;
    rsp         = '0;
    push_req    = 1'b0;
    push_to_hi  = cur_op_r.task_high;
    push_ok     = 1'b0;

    if (exec) begin
      if (!cur_op_r.sched) begin
        push_req = 1'b1;
      end else if (hi_fill_r != '0) begin
        rsp.next_valid = 1'b1;
        rsp.next_id    = hi_rdata;
        push_req       = cur_op_r.has_task;
        hi_fill_nxt    = hi_fill_r - FW'(1);
        hi_head_nxt    = (hi_head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : hi_head_r + AW'(1);
      end else if (cur_op_r.has_task && cur_op_r.task_high) begin
        rsp.next_valid = 1'b1;
        rsp.next_id    = cur_op_r.task_id;
        rsp.kept_prev  = 1'b1;
        local_nxt      = local_r + CW'(1);
      end else begin
        skip_nxt = skip_r + CW'(1);
        if (lo_fill_r != '0) begin
          rsp.next_valid = 1'b1;
          rsp.next_id    = lo_rdata;
          push_req       = cur_op_r.has_task;
          lo_fill_nxt    = lo_fill_r - FW'(1);
          lo_head_nxt    = (lo_head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : lo_head_r + AW'(1);
        end else if (cur_op_r.has_task) begin
          rsp.next_valid = 1'b1;
          rsp.next_id    = cur_op_r.task_id;
          rsp.kept_prev  = 1'b1;
          local_nxt      = local_r + CW'(1);
        end else begin
          idle_nxt = idle_r + CW'(1);
        end
      end
    end

    // push lands after any pop of this request
    tgt_head = push_to_hi ? hi_head_nxt : lo_head_nxt;
    tgt_fill = push_to_hi ? hi_fill_nxt : lo_fill_nxt;
    pos_sum  = FW'(tgt_head) + tgt_fill;
    waddr    = (pos_sum >= FW'(QUEUE_DEPTH)) ? AW'(pos_sum - FW'(QUEUE_DEPTH))
                                            : AW'(pos_sum);
    if (push_req) begin
      if (tgt_fill == FW'(QUEUE_DEPTH)) begin
        rsp.push_dropped = 1'b1;
      end else begin
        push_ok = 1'b1;
        if (push_to_hi) begin
          hi_fill_nxt = hi_fill_nxt + FW'(1);
        end else begin
          lo_fill_nxt = lo_fill_nxt + FW'(1);
        end
      end
    end

    rsp.local_count     = local_nxt;
    rsp.skip_high_count = skip_nxt;
    rsp.idle_count      = idle_nxt;
  end

  tsch_ram #(.WIDTH(IW), .DEPTH(QUEUE_DEPTH)) u_hi_ram (
    .clk   (clk),
    .we    (push_ok && push_to_hi),
    .waddr (waddr),
    .wdata (cur_op_r.task_id),
    .re    (rd_en),
    .raddr (hi_head_r),
    .rdata (hi_rdata)
  );

  tsch_ram #(.WIDTH(IW), .DEPTH(QUEUE_DEPTH)) u_lo_ram (
    .clk   (clk),
    .we    (push_ok && !push_to_hi),
    .waddr (waddr),
    .wdata (cur_op_r.task_id),
    .re    (rd_en),
    .raddr (lo_head_r),
    .rdata (lo_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hi_head_r   <= '0;
      lo_head_r   <= '0;
      hi_fill_r   <= '0;
      lo_fill_r   <= '0;
      local_r     <= '0;
      skip_r      <= '0;
      idle_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hi_head_r   <= hi_head_nxt;
      lo_head_r   <= lo_head_nxt;
      hi_fill_r   <= hi_fill_nxt;
      lo_fill_r   <= lo_fill_nxt;
      local_r     <= local_nxt;
      skip_r      <= skip_nxt;
      idle_r      <= idle_nxt;
      out_valid_r <= exec;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_op_r <= qhead.op;
    end
    if (exec) begin
      out_data_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (hi_fill_r <= FW'(QUEUE_DEPTH)) && (lo_fill_r <= FW'(QUEUE_DEPTH)))
    else $error("FIFO fill beyond depth");

  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_EXEC))
    else $error("result strobe without an executed request");

  a_kept_has_task: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.kept_prev) |-> out_data_r.next_valid)
    else $error("kept previous task without a pick");

  a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> (state_r == S_IDLE))
    else $error("execute state held past one cycle");
`endif

endmodule

### rtl/two_level_fifo_task_scheduler.sv
// Channel   Ports                        Handshake
// request   start, busy, in_data         taken when start && !busy
// result    out_valid, out_data          one-cycle strobe, no back-pressure
//
// With the back end idle, a taken request goes through the request queue, the
// FIFO RAM read, execute and the result register. The back end takes one
// request at a time (FIFO RAM read, then execute) and pops no new one while
// executing. A two-entry request queue sits between the front and back ends;
// busy is high while it is full. Synchronous reset clears heads, fills,
// counters and the queue; FIFO contents stay as they are.
module two_level_fifo_task_scheduler #(
  parameter int QUEUE_DEPTH = tsch_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tsch_pkg::in_req_t  in_data,
  output logic               out_valid,
  output tsch_pkg::out_rsp_t out_data
);

  tsch_pkg::qhead_t qhead;
  logic             q_pop;

  tsch_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .qhead   (qhead),
    .q_pop   (q_pop)
  );

  tsch_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qhead     (qhead),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
